[rtl/core/pru_pkg.sv]
// ----------------------------------------------------------------------------
// pru_pkg
// Shared codes and field types for the pixel replicating upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam logic       OP_PUSH = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [6:0] SCALE_MAX = 7'd100;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic       from_ram;
    pixel_t     pix;
    logic [6:0] repeat_count;
    logic       row_last;
    logic [1:0] pad_bytes;
    logic       frame_last;
  } out_item_t;

endpackage

[rtl/core/pixel_replicating_upscaler.sv]
// A result is held in the output register in the cycle after its transaction is accepted.
// Throughput: one push or replay tick per cycle while the output is not stalled,
//   set by the single output register and the registered read of the line buffer RAM.
// Reset: counters clear, the block accepts pixels, scale/width/height read 1;
//   the line buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// pixel_replicating_upscaler
// Nearest-neighbor integer upscaler for 24-bit RGB rows with line-buffer replay.
// ----------------------------------------------------------------------------
module pixel_replicating_upscaler #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // red_in, green_in, blue_in
  input  logic        s_axis_tuser_i,  // opcode
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // red, green, blue, repeat_count, pad_bytes, zeros
  output logic        m_axis_tlast_o,  // row_last
  output logic        m_axis_tuser_o   // frame_last
);
  import pru_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = AW + 1;

  // configuration registers
  logic [6:0]  scale_q;
  logic [12:0] width_q;
  logic [15:0] height_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= 7'd1;
      width_q  <= 13'd1;
      height_q <= 16'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SCALE:  scale_q  <= pwdata[6:0];
        REG_WIDTH:  width_q  <= pwdata[12:0];
        REG_HEIGHT: height_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SCALE:  prdata = {25'd0, scale_q};
      REG_WIDTH:  prdata = {19'd0, width_q};
      REG_HEIGHT: prdata = {16'd0, height_q};
      default:    prdata = 32'd0;
    endcase
  end

  // effective (clamped) geometry
  logic [6:0]    eff_s;
  logic [CW-1:0] eff_w;
  logic [15:0]   eff_h;

  always_comb begin
    if (scale_q == 7'd0)          eff_s = 7'd1;
    else if (scale_q > SCALE_MAX) eff_s = SCALE_MAX;
    else                          eff_s = scale_q;

    if (width_q == 13'd0)                   eff_w = CW'(1);
    else if (int'(width_q) > MAX_WIDTH)     eff_w = CW'(MAX_WIDTH);
    else                                    eff_w = CW'(width_q);

    eff_h = (height_q == 16'd0) ? 16'd1 : height_q;
  end

  // control state
  logic [AW-1:0] col_q, col_d;
  logic [6:0]    copy_q, copy_d;
  logic [15:0]   row_q, row_d;
  logic          replay_q, replay_d;

  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic s_acc, emit, is_push, is_tick;
  logic row_end, copy_end, frame_end;
  logic [1:0] ws_lo, pad;
  logic [23:0] ram_rdata;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign is_push = (s_axis_tuser_i == OP_PUSH);
  assign is_tick = (s_axis_tuser_i == OP_TICK);
  // drop items that arrive in the wrong phase
  assign emit    = s_acc & ((is_push & !replay_q) | (is_tick & replay_q));

  assign row_end   = (CW'({1'b0, col_q}) + CW'(1)) >= eff_w;
  assign copy_end  = ({1'b0, copy_q} + 8'd1) >= {1'b0, eff_s};
  assign frame_end = ({1'b0, row_q} + 17'd1) >= {1'b0, eff_h};

  // pad = (-3*w*s) mod 4, only the two low bits of w and s matter
  assign ws_lo = 2'(eff_w[1:0] * eff_s[1:0]);
  assign pad   = 2'(2'd0 - 2'(ws_lo * 2'd3));

  always_comb begin
    col_d    = col_q;
    copy_d   = copy_q;
    row_d    = row_q;
    replay_d = replay_q;
    if (emit) begin
      if (row_end) begin
        col_d = '0;
        if (copy_end) begin
          copy_d   = 7'd0;
          replay_d = 1'b0;
          row_d    = frame_end ? 16'd0 : row_q + 16'd1;
        end else begin
          copy_d   = copy_q + 7'd1;
          replay_d = 1'b1;
        end
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_comb begin
    out_d              = out_q;
    out_valid_d        = out_valid_q;
    if (s_axis_tready_o) begin
      out_valid_d = emit;
      if (emit) begin
        out_d.from_ram     = is_tick;
        out_d.pix          = s_axis_tdata_i;
        out_d.repeat_count = eff_s;
        out_d.row_last     = row_end;
        out_d.pad_bytes    = row_end ? pad : 2'd0;
        out_d.frame_last   = row_end & copy_end & frame_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      copy_q      <= 7'd0;
      row_q       <= 16'd0;
      replay_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      copy_q      <= copy_d;
      row_q       <= row_d;
      replay_q    <= replay_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // line buffer: pushes write at the column, ticks read it back
  pru_ram #(
    .WIDTH (24),
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (emit & is_push),
    .waddr_i (col_q),
    .wdata_i (s_axis_tdata_i),
    .re_i    (emit & is_tick),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  pixel_t out_pix;
  assign out_pix = out_q.from_ram ? pixel_t'(ram_rdata) : out_q.pix;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.pad_bytes, out_q.repeat_count,
                            out_pix.blue, out_pix.green, out_pix.red};
  assign m_axis_tlast_o  = out_q.row_last;
  assign m_axis_tuser_o  = out_q.frame_last;

  // input may only stall behind a held result
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> out_valid_q)
    else $error("input stalled with empty output register");

  a_wrong_phase_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && is_push && replay_q) |=> !m_axis_tvalid_o)
    else $error("push during replay produced a result");

  a_frame_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("frame end without row end");

  a_pad_at_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_q.pad_bytes != 2'd0)) |-> m_axis_tlast_o)
    else $error("pad bytes away from row end");

  a_frame_resets_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && row_end && copy_end && frame_end) |=>
      (row_q == 16'd0 && !replay_q && copy_q == 7'd0))
    else $error("counters not cleared at frame end");

endmodule

[rtl/core/pru_ram.sv]
// ----------------------------------------------------------------------------
// pru_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
